// ----- rtl/kvt_pkg.sv -----
// ============================================================================
// kvt_pkg: shared types and constants of the key/value table
// Sizes of the table, field widths, operation and status codes, and the
// states of the table's sequencer.
// ============================================================================
`default_nettype none

package kvt_pkg;

  // Table size and stored widths.
  localparam int CAPACITY   = 64;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Derived widths.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Port field widths.
  localparam int FUNC_W   = 3;
  localparam int FIELD_W  = 32;
  localparam int RANK_W   = 6;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]      slot_t;
  typedef logic [CNT_W-1:0]      count_t;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 3'd0,
    FUNC_UPDATE = 3'd1,
    FUNC_UPSERT = 3'd2,
    FUNC_ERASE  = 3'd3,
    FUNC_LOOKUP = 3'd4,
    FUNC_RANK   = 3'd5
  } func_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_KEY      = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANK_OOR = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_RANK,
    S_VREAD,
    S_VWAIT,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/kvt_req_if.sv -----
// ============================================================================
// kvt_req_if: request channel of the key/value table
// Valid/ready channel that carries one operation per transfer.
// ============================================================================
`default_nettype none

interface kvt_req_if
  import kvt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [FIELD_W-1:0]  key;
  logic [FIELD_W-1:0]  new_value;
  logic [RANK_W-1:0]   rank;

  modport source (output valid, func, key, new_value, rank, input ready);
  modport sink   (input valid, func, key, new_value, rank, output ready);
endinterface

`default_nettype wire

// ----- rtl/kvt_rsp_if.sv -----
// ============================================================================
// kvt_rsp_if: response channel of the key/value table
// Valid/ready channel that carries one result per transfer.
// ============================================================================
`default_nettype none

interface kvt_rsp_if
  import kvt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FIELD_W-1:0]  found_key;
  logic [FIELD_W-1:0]  found_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_key, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_key, found_value, entry_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/key_value_table_with_rank.sv -----
// ============================================================================
// key_value_table_with_rank: bounded table of unique key/value pairs
// Insert, update, insert-or-update, erase, lookup and fetch by rank over a
// table kept in a key memory and a value memory.
// ============================================================================
// The table holds up to CAPACITY pairs in two synchronous memories (keys
// and values); occupancy is kept in flip-flops that reset clears, so the
// table is empty right after reset with no clearing pass.
// One request is processed at a time. Insert, update, insert-or-update,
// erase and lookup read the whole key memory once, one slot per cycle; a
// lookup that hits then reads the value memory. Fetch by rank finds the
// smallest key, then the next larger one, and so on, with one full pass
// over the key memory for each step, rank + 1 passes in all. A rank out
// of range and the unused codes six and seven go to the result without
// any scan. The result sits in an output register, so processing of the
// next request overlaps the wait for the response to be taken.
`default_nettype none

module key_value_table_with_rank
  import kvt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  kvt_req_if.sink   req,
  kvt_rsp_if.source rsp
);

  state_t state, state_next;

  // Latched request.
  logic [FUNC_W-1:0] op_func;
  key_t              op_key;
  value_t            op_value;
  logic [RANK_W-1:0] op_rank;

  // Occupancy and count.
  logic [CAPACITY-1:0] valid;
  count_t              count;

  // Memories and their registered read data.
  key_t   key_mem [CAPACITY];
  value_t val_mem [CAPACITY];
  key_t   key_rd;
  value_t val_rd;
  slot_t  val_addr;

  // Scan pipeline: address issued, then compare in the next cycle.
  logic [IDX_W:0] scan_idx;
  logic           cmp_vld;
  slot_t          cmp_slot;
  logic           scan_end;
  logic           cmp_hit;

  // Key search results.
  logic  match;
  slot_t match_slot;
  logic  free_found;
  slot_t free_slot;

  // Rank selection state.
  logic              have_prev;
  key_t              prev_key;
  logic              best_found;
  key_t              best_key;
  slot_t             best_slot;
  logic [RANK_W-1:0] pass;
  logic              rank_last;

  // Result held until the output register is free.
  status_t            res_status;
  logic [FIELD_W-1:0] res_key;
  logic [FIELD_W-1:0] res_val;

  // Table changes made in the execute cycle.
  logic    do_insert;
  logic    do_update;
  logic    do_erase;
  status_t exec_status;
  logic    out_free;
  logic    req_rank_oor;

  assign scan_end     = scan_idx[IDX_W] && !cmp_vld;
  assign cmp_hit      = cmp_vld && valid[cmp_slot];
  assign rank_last    = (state == S_RANK) && scan_end && (pass == op_rank);
  assign out_free     = !rsp.valid || rsp.ready;
  assign req_rank_oor = 32'(req.rank) >= 32'(count);
  assign req.ready    = (state == S_IDLE);

  // Decode of the execute cycle.
  always_comb begin
    do_insert   = 1'b0;
    do_update   = 1'b0;
    do_erase    = 1'b0;
    exec_status = ST_DONE;
    if (state == S_EXEC) begin
      case (op_func) inside
        FUNC_INSERT: begin
          if (match) exec_status = ST_KEY;
          else if (!free_found) exec_status = ST_FULL;
          else do_insert = 1'b1;
        end
        FUNC_UPDATE: begin
          if (!match) exec_status = ST_KEY;
          else do_update = 1'b1;
        end
        FUNC_UPSERT: begin
          if (match) do_update = 1'b1;
          else if (!free_found) exec_status = ST_FULL;
          else do_insert = 1'b1;
        end
        FUNC_ERASE, FUNC_LOOKUP: begin
          if (!match) exec_status = ST_KEY;
          else if (op_func == FUNC_ERASE) do_erase = 1'b1;
        end
        default: exec_status = ST_DONE;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.func) inside
            FUNC_INSERT, FUNC_UPDATE, FUNC_UPSERT, FUNC_ERASE, FUNC_LOOKUP:
              state_next = S_SCAN;
            FUNC_RANK: state_next = req_rank_oor ? S_DONE : S_RANK;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (op_func == FUNC_LOOKUP && match) state_next = S_VREAD;
        else state_next = S_DONE;
      end
      S_RANK: begin
        if (rank_last) state_next = S_VREAD;
      end
      S_VREAD: state_next = S_VWAIT;
      S_VWAIT: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Key memory: read one slot per cycle, write on insert.
  always_ff @(posedge clk) begin
    if (do_insert) key_mem[free_slot] <= op_key;
    key_rd <= key_mem[scan_idx[IDX_W-1:0]];
  end

  // Value memory: write on insert or update, read for lookup and rank.
  always_ff @(posedge clk) begin
    if (do_insert) val_mem[free_slot] <= op_value;
    else if (do_update) val_mem[match_slot] <= op_value;
    val_rd <= val_mem[val_addr];
  end

  // Occupancy flags, count, compare pipeline flag and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      count     <= '0;
      cmp_vld   <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (do_insert) begin
        valid[free_slot] <= 1'b1;
        count            <= count + count_t'(1);
      end else if (do_erase) begin
        valid[match_slot] <= 1'b0;
        count             <= count - count_t'(1);
      end
      if (state == S_SCAN || state == S_RANK) begin
        cmp_vld <= !scan_idx[IDX_W] && !(state == S_RANK && scan_end);
      end else begin
        cmp_vld <= 1'b0;
      end
      if (state == S_DONE && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // Request latch, search, rank selection and result registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op_func    <= req.func;
        op_key     <= key_t'(req.key);
        op_value   <= value_t'(req.new_value);
        op_rank    <= req.rank;
        scan_idx   <= '0;
        match      <= 1'b0;
        free_found <= 1'b0;
        have_prev  <= 1'b0;
        best_found <= 1'b0;
        pass       <= '0;
        res_key    <= '0;
        res_val    <= '0;
        res_status <= (req.func == FUNC_RANK && req_rank_oor) ? ST_RANK_OOR : ST_DONE;
      end
      S_SCAN: begin
        if (!scan_idx[IDX_W]) scan_idx <= scan_idx + (IDX_W+1)'(1);
        cmp_slot <= scan_idx[IDX_W-1:0];
        if (cmp_hit && key_rd == op_key) begin
          match      <= 1'b1;
          match_slot <= cmp_slot;
        end
        if (cmp_vld && !valid[cmp_slot] && !free_found) begin
          free_found <= 1'b1;
          free_slot  <= cmp_slot;
        end
      end
      S_EXEC: begin
        res_status <= exec_status;
        if (op_func == FUNC_LOOKUP && match) begin
          res_key  <= FIELD_W'(op_key);
          val_addr <= match_slot;
        end
      end
      S_RANK: begin
        cmp_slot <= scan_idx[IDX_W-1:0];
        if (scan_end) begin
          // End of a pass: either the wanted entry or the next lower bound.
          if (pass == op_rank) begin
            res_key  <= FIELD_W'(best_key);
            val_addr <= best_slot;
          end else begin
            scan_idx   <= '0;
            have_prev  <= 1'b1;
            prev_key   <= best_key;
            best_found <= 1'b0;
            pass       <= pass + RANK_W'(1);
          end
        end else begin
          if (!scan_idx[IDX_W]) scan_idx <= scan_idx + (IDX_W+1)'(1);
          // Keep the smallest key above the previous pass's result.
          if (cmp_hit && (!have_prev || key_rd > prev_key) &&
              (!best_found || key_rd < best_key)) begin
            best_found <= 1'b1;
            best_key   <= key_rd;
            best_slot  <= cmp_slot;
          end
        end
      end
      S_VWAIT: begin
        res_val <= FIELD_W'(val_rd);
      end
      default: begin
      end
    endcase
  end

  // Output register load.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.status      <= res_status;
      rsp.found_key   <= res_key;
      rsp.found_value <= res_val;
      rsp.entry_count <= COUNT_W'(count);
    end
  end

  // The count always agrees with the occupancy flags.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(valid))
    else $error("entry count differs from number of occupied slots");

  // The table never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("entry count above capacity");

  // An insert grows the count by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> count == $past(count) + count_t'(1))
    else $error("insert did not increment the count");

  // The final rank pass always has found an entry.
  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    rank_last |-> best_found)
    else $error("rank fetch ended without an entry");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready && state == S_DONE |=> state == S_DONE)
    else $error("sequencer left done state while output was blocked");

endmodule

`default_nettype wire

// ----- tb/sv/key_value_table_with_rank_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// key_value_table_with_rank_test: self-checking bench of the key/value table
// Drives table operations over the request channel and checks every result
// on the response channel against a table kept in the bench. A short
// directed opening covers the corner cases; random phases then fill, drain
// and churn the table, with random idle cycles on both channels.
// ============================================================================

module key_value_table_with_rank_test;
  import kvt_pkg::*;

  // Spare operation codes that the block must treat as no-ops.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

  localparam int RANDOM_OPS   = 1500;
  localparam int POOL_SIZE    = 96;
  localparam int LIMIT_CYCLES = 40_000_000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [FUNC_W-1:0] func;
    key_t              key;
    value_t            new_value;
    logic [RANK_W-1:0] rank;
  } table_op_t;

  typedef struct {
    status_t            status;
    logic [FIELD_W-1:0] found_key;
    logic [FIELD_W-1:0] found_value;
    logic [COUNT_W-1:0] entry_count;
  } table_result_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} load_mode_t;

  logic clk = 1'b0;
  logic rst;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  key_value_table_with_rank dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the table: key -> value, iterated in ascending key order.
  value_t        stored_pairs [bit [KEY_BITS-1:0]];
  table_op_t     pending_ops [$];
  table_result_t expected_results [$];
  key_t          key_pool [POOL_SIZE];

  int  issued_ops   = 0;
  int  accepted_ops = 0;
  int  error_count  = 0;
  int  cycle_count  = 0;
  bit  steady_flow  = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one operation to the bench table and returns the result it gives.
  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t res;
    bit            hit;
    bit            done;
    int            pos;
    res  = '{ST_DONE, '0, '0, '0};
    hit  = stored_pairs.exists(op.key);
    done = 1'b0;
    pos  = 0;
    case (op.func)
      FUNC_INSERT: begin
        if (hit) res.status = ST_KEY;
        else if (stored_pairs.num() >= CAPACITY) res.status = ST_FULL;
        else stored_pairs[op.key] = op.new_value;
      end
      FUNC_UPDATE: begin
        if (!hit) res.status = ST_KEY;
        else stored_pairs[op.key] = op.new_value;
      end
      FUNC_UPSERT: begin
        if (hit) stored_pairs[op.key] = op.new_value;
        else if (stored_pairs.num() >= CAPACITY) res.status = ST_FULL;
        else stored_pairs[op.key] = op.new_value;
      end
      FUNC_ERASE: begin
        if (!hit) res.status = ST_KEY;
        else stored_pairs.delete(op.key);
      end
      FUNC_LOOKUP: begin
        if (!hit) begin
          res.status = ST_KEY;
        end else begin
          res.found_key   = op.key;
          res.found_value = stored_pairs[op.key];
        end
      end
      FUNC_RANK: begin
        if (int'(op.rank) >= stored_pairs.num()) begin
          res.status = ST_RANK_OOR;
        end else begin
          // Walk keys in ascending order up to the requested position.
          foreach (stored_pairs[stored_key]) begin
            if (!done && pos == int'(op.rank)) begin
              res.found_key   = stored_key;
              res.found_value = stored_pairs[stored_key];
              done = 1'b1;
            end
            pos++;
          end
        end
      end
      default: begin
      end
    endcase
    res.entry_count = COUNT_W'(stored_pairs.num());
    return res;
  endfunction

  // Returns a key that is currently stored; the table must not be empty.
  function automatic key_t pick_stored_key();
    int   target;
    int   pos;
    key_t chosen;
    target = $urandom_range(0, stored_pairs.num() - 1);
    pos    = 0;
    chosen = '0;
    foreach (stored_pairs[stored_key]) begin
      if (pos == target) chosen = stored_key;
      pos++;
    end
    return chosen;
  endfunction

  // Idle length between transfers: mostly short, now and then long.
  function automatic int idle_cycles();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady_flow) return 0;
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [FIELD_W-1:0] expected,
                                      logic [FIELD_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected, actual);
      error_count++;
    end
  endfunction

  task automatic push_op(logic [FUNC_W-1:0] func, key_t key, value_t new_value,
                         logic [RANK_W-1:0] rank);
    pending_ops.push_back('{func, key, new_value, rank});
    issued_ops++;
  endtask

  // Request driver: presents queued operations and predicts each transfer.
  always @(posedge clk) begin : drive_requests
    table_op_t op;
    static table_op_t in_flight;
    static int        send_gap = 0;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results.push_back(apply_table_op(in_flight));
        accepted_ops++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          op        = pending_ops.pop_front();
          in_flight = op;
          req_ch.func      <= op.func;
          req_ch.key       <= op.key;
          req_ch.new_value <= op.new_value;
          req_ch.rank      <= op.rank;
          req_ch.valid     <= 1'b1;
          send_gap = idle_cycles();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each transfer and stalls ready at random.
  always @(posedge clk) begin : collect_results
    table_result_t expected;
    static int recv_gap = 0;
    int        stall;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("response transfer with no request outstanding");
          error_count++;
        end else begin
          expected = expected_results.pop_front();
          check_field("status", FIELD_W'(expected.status), FIELD_W'(rsp_ch.status));
          check_field("found_key", expected.found_key, rsp_ch.found_key);
          check_field("found_value", expected.found_value, rsp_ch.found_value);
          check_field("entry_count", FIELD_W'(expected.entry_count),
                      FIELD_W'(rsp_ch.entry_count));
        end
        stall = idle_cycles();
      end else if (recv_gap == 0 && $urandom_range(0, 9) == 0) begin
        stall = idle_cycles();
      end else begin
        stall = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        rsp_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        recv_gap = stall - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    load_mode_t        mode;
    int                seg_len;
    int                pick;
    int                hit_pct;
    int                count;
    logic [FUNC_W-1:0] func;
    key_t              key;
    value_t            new_value;
    logic [RANK_W-1:0] rank;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.func      = '0;
    req_ch.key       = '0;
    req_ch.new_value = '0;
    req_ch.rank      = '0;
    rsp_ch.ready     = 1'b0;

    // Key pool: extremes plus random keys, larger than the table.
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h0000_0001;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: empty table, duplicates, extremes, rank bounds, spares.
    push_op(FUNC_LOOKUP, 32'h0, 32'h0, 6'd0);
    push_op(FUNC_RANK, 32'h0, 32'h0, 6'd0);
    push_op(FUNC_UPDATE, 32'h5, 32'h1234_5678, 6'd0);
    push_op(FUNC_ERASE, 32'h5, 32'h0, 6'd0);
    push_op(FUNC_INSERT, 32'h0, 32'h0, 6'd0);
    push_op(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
    push_op(FUNC_INSERT, 32'h0, 32'h1, 6'd0);
    push_op(FUNC_UPSERT, 32'hFFFF_FFFF, 32'h0, 6'd0);
    push_op(FUNC_UPSERT, 32'h8000_0000, 32'h5555_5555, 6'd0);
    push_op(FUNC_UPDATE, 32'h0, 32'hAAAA_AAAA, 6'd0);
    push_op(FUNC_LOOKUP, 32'h0, 32'h0, 6'd0);
    push_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 6'd0);
    push_op(FUNC_RANK, 32'h0, 32'h0, 6'd0);
    push_op(FUNC_RANK, 32'h0, 32'h0, 6'd2);
    push_op(FUNC_RANK, 32'h0, 32'h0, 6'd3);
    push_op(FUNC_RANK, 32'h0, 32'h0, 6'd63);
    push_op(FUNC_SPARE_LO, 32'h8000_0000, 32'hFFFF_FFFF, 6'd1);
    push_op(FUNC_SPARE_HI, 32'hFFFF_FFFF, 32'h1, 6'd63);
    push_op(FUNC_ERASE, 32'h8000_0000, 32'h0, 6'd0);
    push_op(FUNC_LOOKUP, 32'h8000_0000, 32'h0, 6'd0);
    push_op(FUNC_ERASE, 32'h0, 32'h0, 6'd0);
    push_op(FUNC_ERASE, 32'hFFFF_FFFF, 32'h0, 6'd0);

    // Random phases. Each picks a load mode; some run with no idling.
    mode = MODE_FILL;
    while (issued_ops < RANDOM_OPS + 22) begin
      seg_len     = $urandom_range(60, 160);
      steady_flow = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < seg_len; n++) begin
        // Stay close to the driver so choices track the current table.
        while (pending_ops.size() >= 2) @(posedge clk);
        count = stored_pairs.num();

        pick = $urandom_range(0, 99);
        case (mode)
          MODE_FILL: begin
            hit_pct = 20;
            func = pick < 45 ? FUNC_INSERT : pick < 70 ? FUNC_UPSERT :
                   pick < 78 ? FUNC_UPDATE : pick < 86 ? FUNC_LOOKUP :
                   pick < 94 ? FUNC_RANK   : pick < 98 ? FUNC_ERASE  :
                   FUNC_SPARE_LO;
          end
          MODE_DRAIN: begin
            hit_pct = 70;
            func = pick < 45 ? FUNC_ERASE  : pick < 60 ? FUNC_LOOKUP :
                   pick < 70 ? FUNC_RANK   : pick < 80 ? FUNC_UPDATE :
                   pick < 88 ? FUNC_INSERT : pick < 97 ? FUNC_UPSERT :
                   FUNC_SPARE_HI;
          end
          default: begin
            hit_pct = 45;
            func = pick < 18 ? FUNC_INSERT : pick < 34 ? FUNC_UPDATE :
                   pick < 52 ? FUNC_UPSERT : pick < 68 ? FUNC_ERASE  :
                   pick < 84 ? FUNC_LOOKUP : pick < 96 ? FUNC_RANK   :
                   ($urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO);
          end
        endcase

        // Keys: mostly stored ones or pool keys, a few fully random.
        pick = $urandom_range(0, 99);
        if (count > 0 && pick < hit_pct) key = pick_stored_key();
        else if (pick < 95) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else key = $urandom;

        pick = $urandom_range(0, 99);
        if (pick < 8) new_value = '0;
        else if (pick < 16) new_value = '1;
        else new_value = $urandom;

        // Ranks: mostly in range, with the largest and the top code covered.
        pick = $urandom_range(0, 99);
        if (count > 0 && pick < 70) rank = RANK_W'($urandom_range(0, count - 1));
        else if (count > 0 && pick < 80) rank = RANK_W'(count - 1);
        else if (pick < 90) rank = RANK_W'($urandom_range(0, 63));
        else rank = 6'd63;

        push_op(func, key, new_value, rank);
      end

      pick = $urandom_range(0, 9);
      mode = pick < 4 ? MODE_FILL : pick < 7 ? MODE_DRAIN : MODE_MIXED;
    end

    // Wait for every request to be taken and answered, then let it settle.
    while (accepted_ops < issued_ops || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
